>>> hw/rtl/bptc_pkg.sv
package bptc_pkg;

    localparam int IDX_W  = 3;
    localparam int COEF_W = 16;
    localparam int RAW_W  = 24;
    localparam int ACC_W  = 48;
    localparam int DT_W   = 25;
    localparam int TD_W   = 19;
    localparam int T2_W   = 18;
    localparam int PRES_W = 18;
    localparam int TEMP_W = 16;

    localparam logic [IDX_W-1:0] REG_C1      = 3'd0;
    localparam logic [IDX_W-1:0] REG_C2      = 3'd1;
    localparam logic [IDX_W-1:0] REG_C3      = 3'd2;
    localparam logic [IDX_W-1:0] REG_C4      = 3'd3;
    localparam logic [IDX_W-1:0] REG_C5      = 3'd4;
    localparam logic [IDX_W-1:0] REG_C6      = 3'd5;
    localparam logic [IDX_W-1:0] REG_VARIANT = 3'd6;

    localparam int TEMP_REF = 2000;
    localparam int TEMP_LOW = -1500;
    localparam int TEMP_MIN = -32768;
    localparam int TEMP_MAX = 32767;
    localparam int PRES_MAX = 262143;

    typedef struct packed {
        logic [RAW_W-1:0] raw_pressure;
        logic [RAW_W-1:0] raw_temperature;
    } in_t;

    typedef struct packed {
        logic [PRES_W-1:0]        pressure_out;
        logic signed [TEMP_W-1:0] temperature_out;
        logic                     out_of_range;
    } out_t;

    typedef struct packed {
        logic [COEF_W-1:0] c1;
        logic [COEF_W-1:0] c2;
        logic [COEF_W-1:0] c3;
        logic [COEF_W-1:0] c4;
        logic [COEF_W-1:0] c5;
        logic [COEF_W-1:0] c6;
        logic              variant;
    } coef_t;

    // first-order results
    typedef struct packed {
        logic [RAW_W-1:0]        d1;
        logic signed [ACC_W-1:0] off;
        logic signed [ACC_W-1:0] sens;
        logic signed [TD_W-1:0]  d;
        logic signed [TD_W-1:0]  e;
        logic [T2_W-1:0]         t2;
    } front_t;

    // second-order corrected results
    typedef struct packed {
        logic [RAW_W-1:0]         d1;
        logic signed [ACC_W-1:0]  off;
        logic signed [ACC_W-1:0]  sens;
        logic signed [TEMP_W-1:0] temperature;
        logic                     tflag;
    } second_t;

endpackage

>>> hw/rtl/bptc_front.sv
module bptc_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bptc_pkg::coef_t      coef,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  bptc_pkg::in_t        in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output bptc_pkg::front_t     out_data
);

    localparam int NS = 3;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] en;

    // stage 1
    logic [23:0]        s1_d1_reg;
    logic signed [24:0] s1_dt_reg;
    logic signed [24:0] s1_dt_next;
    // stage 2
    logic [23:0]        s2_d1_reg;
    logic signed [41:0] s2_p3_reg, s2_p4_reg, s2_p6_reg;
    logic signed [49:0] s2_pdt_reg;
    logic signed [41:0] s2_p3_next, s2_p4_next, s2_p6_next;
    logic signed [49:0] s2_pdt_next;
    // stage 3
    bptc_pkg::front_t   s3_reg;
    bptc_pkg::front_t   s3_next;

    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || out_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NS-1];
    assign out_data  = s3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // dt = D2 - C5 * 256
    assign s1_dt_next = $signed({1'b0, in_data.raw_temperature})
                      - $signed({1'b0, coef.c5, 8'b0});

    assign s2_p3_next  = 42'($signed({1'b0, coef.c3})) * 42'(s1_dt_reg);
    assign s2_p4_next  = 42'($signed({1'b0, coef.c4})) * 42'(s1_dt_reg);
    assign s2_p6_next  = 42'($signed({1'b0, coef.c6})) * 42'(s1_dt_reg);
    assign s2_pdt_next = 50'(s1_dt_reg) * 50'(s1_dt_reg);

    always_comb
    begin
        logic signed [18:0] dd;
        dd = 19'(s2_p6_reg >>> 23);
        s3_next.d1 = s2_d1_reg;
        if (coef.variant)
        begin
            s3_next.off  = 48'({coef.c2, 17'b0}) + 48'(s2_p4_reg >>> 6);
            s3_next.sens = 48'({coef.c1, 16'b0}) + 48'(s2_p3_reg >>> 7);
        end
        else
        begin
            s3_next.off  = 48'({coef.c2, 16'b0}) + 48'(s2_p4_reg >>> 7);
            s3_next.sens = 48'({coef.c1, 15'b0}) + 48'(s2_p3_reg >>> 8);
        end
        // d = temp - 2000, e = temp + 1500
        s3_next.d  = dd;
        s3_next.e  = dd + 19'(bptc_pkg::TEMP_REF - bptc_pkg::TEMP_LOW);
        s3_next.t2 = 18'(s2_pdt_reg >>> 31);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_d1_reg <= in_data.raw_pressure;
            s1_dt_reg <= s1_dt_next;
        end
        if (en[1])
        begin
            s2_d1_reg  <= s1_d1_reg;
            s2_p3_reg  <= s2_p3_next;
            s2_p4_reg  <= s2_p4_next;
            s2_p6_reg  <= s2_p6_next;
            s2_pdt_reg <= s2_pdt_next;
        end
        if (en[2])
        begin
            s3_reg <= s3_next;
        end
    end

endmodule

>>> hw/rtl/bptc_second.sv
module bptc_second (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 variant,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  bptc_pkg::front_t     in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output bptc_pkg::second_t    out_data
);

    localparam int NS = 3;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] en;

    // stage 4: squares
    logic [23:0]        s4_d1_reg;
    logic signed [47:0] s4_off_reg, s4_sens_reg;
    logic [35:0]        s4_dsq_reg, s4_esq_reg;
    logic               s4_lo_reg, s4_vlo_reg;
    logic signed [19:0] s4_temp_reg;
    logic [17:0]        s4_t2_reg;
    logic signed [37:0] sq_d, sq_e;
    // stage 5: correction terms
    logic [23:0]        s5_d1_reg;
    logic signed [47:0] s5_off_reg, s5_sens_reg;
    logic [47:0]        s5_offc_reg, s5_sensc_reg;
    logic [47:0]        s5_offc_next, s5_sensc_next;
    logic               s5_lo_reg;
    logic signed [19:0] s5_temp_reg;
    logic [17:0]        s5_t2_reg;
    // stage 6
    bptc_pkg::second_t  s6_reg;
    bptc_pkg::second_t  s6_next;

    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || out_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NS-1];
    assign out_data  = s6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    assign sq_d = 38'(in_data.d) * 38'(in_data.d);
    assign sq_e = 38'(in_data.e) * 38'(in_data.e);

    // all terms are non-negative, so the shifts are plain right shifts
    always_comb
    begin
        logic [47:0] xd, xe, hd, he;
        xd = 48'(s4_dsq_reg);
        xe = 48'(s4_esq_reg);
        if (variant)
        begin
            hd = ((xd << 6) - (xd << 1) - xd) >> 4;
            he = (xe << 4) - xe;
            s5_offc_next  = hd + (s4_vlo_reg ? he : 48'd0);
            s5_sensc_next = (xd << 1) + (s4_vlo_reg ? (xe << 3) : 48'd0);
        end
        else
        begin
            hd = (xd << 2) + xd;
            he = (xe << 3) - xe;
            s5_offc_next  = (hd >> 1) + (s4_vlo_reg ? he : 48'd0);
            s5_sensc_next = (hd >> 2)
                          + (s4_vlo_reg ? (((xe << 3) + (xe << 1) + xe) >> 1) : 48'd0);
        end
        if (!s4_lo_reg)
        begin
            s5_offc_next  = '0;
            s5_sensc_next = '0;
        end
    end

    always_comb
    begin
        logic signed [20:0] tfull;
        tfull = 21'(s5_temp_reg) - (s5_lo_reg ? 21'(s5_t2_reg) : 21'd0);
        s6_next.d1   = s5_d1_reg;
        s6_next.off  = s5_off_reg - $signed(s5_offc_reg);
        s6_next.sens = s5_sens_reg - $signed(s5_sensc_reg);
        if (tfull < 21'(bptc_pkg::TEMP_MIN))
        begin
            s6_next.temperature = 16'(bptc_pkg::TEMP_MIN);
            s6_next.tflag       = 1'b1;
        end
        else if (tfull > 21'(bptc_pkg::TEMP_MAX))
        begin
            s6_next.temperature = 16'(bptc_pkg::TEMP_MAX);
            s6_next.tflag       = 1'b1;
        end
        else
        begin
            s6_next.temperature = 16'(tfull);
            s6_next.tflag       = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s4_d1_reg   <= in_data.d1;
            s4_off_reg  <= in_data.off;
            s4_sens_reg <= in_data.sens;
            s4_dsq_reg  <= sq_d[35:0];
            s4_esq_reg  <= sq_e[35:0];
            s4_lo_reg   <= in_data.d[18];
            s4_vlo_reg  <= in_data.e[18];
            s4_temp_reg <= 20'(in_data.d) + 20'(bptc_pkg::TEMP_REF);
            s4_t2_reg   <= in_data.t2;
        end
        if (en[1])
        begin
            s5_d1_reg    <= s4_d1_reg;
            s5_off_reg   <= s4_off_reg;
            s5_sens_reg  <= s4_sens_reg;
            s5_offc_reg  <= s5_offc_next;
            s5_sensc_reg <= s5_sensc_next;
            s5_lo_reg    <= s4_lo_reg;
            s5_temp_reg  <= s4_temp_reg;
            s5_t2_reg    <= s4_t2_reg;
        end
        if (en[2])
        begin
            s6_reg <= s6_next;
        end
    end

endmodule

>>> hw/rtl/bptc_press.sv
module bptc_press (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  bptc_pkg::second_t    in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output bptc_pkg::out_t       out_data
);

    localparam int NS = 4;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] en;

    // stage 7: partial products of D1 * SENS
    logic [43:0]        s7_pl_reg;
    logic signed [52:0] s7_ph_reg;
    logic signed [47:0] s7_off_reg;
    logic signed [15:0] s7_temp_reg;
    logic               s7_tflag_reg;
    // stage 8
    logic signed [63:0] s8_prod_reg;
    logic signed [47:0] s8_off_reg;
    logic signed [15:0] s8_temp_reg;
    logic               s8_tflag_reg;
    // stage 9
    logic signed [63:0] s9_x_reg;
    logic signed [15:0] s9_temp_reg;
    logic               s9_tflag_reg;
    // stage 10
    bptc_pkg::out_t     s10_reg;
    bptc_pkg::out_t     s10_next;

    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || out_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NS-1];
    assign out_data  = s10_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_comb
    begin
        logic signed [63:0] pw;
        pw = s9_x_reg >>> 15;
        s10_next.temperature_out = s9_temp_reg;
        if (pw < 64'sd0)
        begin
            s10_next.pressure_out = '0;
            s10_next.out_of_range = 1'b1;
        end
        else if (pw > 64'(bptc_pkg::PRES_MAX))
        begin
            s10_next.pressure_out = 18'(bptc_pkg::PRES_MAX);
            s10_next.out_of_range = 1'b1;
        end
        else
        begin
            s10_next.pressure_out = 18'(pw);
            s10_next.out_of_range = s9_tflag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s7_pl_reg    <= 44'(in_data.d1) * 44'(in_data.sens[19:0]);
            s7_ph_reg    <= 53'($signed({1'b0, in_data.d1}))
                          * 53'($signed(in_data.sens[47:20]));
            s7_off_reg   <= in_data.off;
            s7_temp_reg  <= in_data.temperature;
            s7_tflag_reg <= in_data.tflag;
        end
        if (en[1])
        begin
            s8_prod_reg  <= (64'(s7_ph_reg) <<< 20) + $signed(64'(s7_pl_reg));
            s8_off_reg   <= s7_off_reg;
            s8_temp_reg  <= s7_temp_reg;
            s8_tflag_reg <= s7_tflag_reg;
        end
        if (en[2])
        begin
            s9_x_reg     <= (s8_prod_reg >>> 21) - 64'(s8_off_reg);
            s9_temp_reg  <= s8_temp_reg;
            s9_tflag_reg <= s8_tflag_reg;
        end
        if (en[3])
        begin
            s10_reg <= s10_next;
        end
    end

endmodule

>>> hw/rtl/baro_pressure_temp_compensation.sv
// Barometric pressure and temperature compensation, second order.
// Input channel: in_valid / in_stall carry one raw pressure and raw temperature
// conversion pair per request (in_data). Output channel: out_valid / out_stall
// carry the compensated pressure (0.01 mbar), temperature (0.01 degC) and the
// saturation flag (out_data). A request moves when valid is high and stall low.
// Calibration words and the variant select are written through cfg_we,
// cfg_index and cfg_data, one register per clock. The user must write them
// only while no request is in flight; the block itself does not enforce this.
// Indexes beyond the variant select are ignored. The pipeline holds three
// stages of first-order maths, three of second-order correction and
// temperature clamping, and four for the 24 x 48 bit pressure product, offset
// and clamping. Throughput is one request per cycle while out_stall is low;
// every stage holds its own valid bit.
// When the receiver stalls the output register holds its request, stages
// behind it still fill any empty slots, and in_stall rises only once the
// stage at the head of the pipeline is full and cannot move on.
// Reset clears all valid bits and sets every calibration register to zero.
module baro_pressure_temp_compensation (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  bptc_pkg::in_t                   in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output bptc_pkg::out_t                  out_data,
    input  logic                            cfg_we,
    input  logic [bptc_pkg::IDX_W-1:0]      cfg_index,
    input  logic [bptc_pkg::COEF_W-1:0]     cfg_data
);

    bptc_pkg::coef_t   coef_reg;
    logic              front_ready, front_valid;
    logic              second_ready, second_valid;
    logic              press_ready;
    bptc_pkg::front_t  front_data;
    bptc_pkg::second_t second_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bptc_pkg::REG_C1:      coef_reg.c1 <= cfg_data;
                bptc_pkg::REG_C2:      coef_reg.c2 <= cfg_data;
                bptc_pkg::REG_C3:      coef_reg.c3 <= cfg_data;
                bptc_pkg::REG_C4:      coef_reg.c4 <= cfg_data;
                bptc_pkg::REG_C5:      coef_reg.c5 <= cfg_data;
                bptc_pkg::REG_C6:      coef_reg.c6 <= cfg_data;
                bptc_pkg::REG_VARIANT: coef_reg.variant <= cfg_data[0];
                default:               coef_reg <= coef_reg;
            endcase
        end
    end

    assign in_stall = !front_ready;

    bptc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .coef      (coef_reg),
        .in_valid  (in_valid),
        .in_ready  (front_ready),
        .in_data   (in_data),
        .out_valid (front_valid),
        .out_ready (second_ready),
        .out_data  (front_data)
    );

    bptc_second u_second (
        .clk       (clk),
        .rst_n     (rst_n),
        .variant   (coef_reg.variant),
        .in_valid  (front_valid),
        .in_ready  (second_ready),
        .in_data   (front_data),
        .out_valid (second_valid),
        .out_ready (press_ready),
        .out_data  (second_data)
    );

    bptc_press u_press (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (second_valid),
        .in_ready  (press_ready),
        .in_data   (second_data),
        .out_valid (out_valid),
        .out_ready (!out_stall),
        .out_data  (out_data)
    );

endmodule
